// File: sv/gsc_pkg.sv
// Shared types and constants for the GPS-to-CET wall-clock converter.
// Holds reciprocal constants for the constant divisions and the date word type.
// No dependencies.
`default_nettype none

package gsc_pkg;

    // register map: word index decoded from paddr[2]
    localparam logic REG_EPOCH_OFFSET = 1'b0;
    localparam logic [29:0] EPOCH_OFFSET_RESET = 30'd315964782;

    localparam int unsigned CIV_LAT = 6;
    localparam int unsigned HM_LAT  = 3;

    // floor(x / 675) = (x * DAY_RECIP) >> 36 for x < 2**26
    localparam logic [26:0] DAY_RECIP     = 27'd101806633;
    // floor(x / 365) = (x * DIV365_RECIP) >> 24 for x < 2**16
    localparam logic [15:0] DIV365_RECIP  = 16'd45965;
    // floor(x / 365) = (x * YOE_RECIP) >> 26 for x < 2**18
    localparam logic [17:0] YOE_RECIP     = 18'd183860;
    // floor(x / 153) = (x * MP_RECIP) >> 20 for x < 2**11
    localparam logic [12:0] MP_RECIP      = 13'd6854;
    // floor(x / 7) = (x * DOW_RECIP) >> 20 for x < 2**17
    localparam logic [17:0] DOW_RECIP     = 18'd149797;
    // floor(x / 225) = (x * HOUR_RECIP) >> 21 for x < 2**13
    localparam logic [13:0] HOUR_RECIP    = 14'd9321;
    // floor(x / 15) = (x * MIN_RECIP) >> 14 for x < 2**10
    localparam logic [10:0] MIN_RECIP     = 11'd1093;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_date;

    // day of the March-based year on which month index mp starts
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] s;
        case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: sv/gps_seconds_to_cet_wallclock_unit.sv
// GPS seconds to CET/CEST wall clock, pipelined from start to o_done;
// one word accepted every cycle (busy stays low), set by a fully pipelined datapath.
// The result strobe cannot be held off. Synchronous active-low reset clears the
// valid pipeline and loads the epoch offset register with its default.
// Uses gsc_pkg, gsc_split, gsc_civil, gsc_hm.
`default_nettype none

module gps_seconds_to_cet_wallclock_unit import gsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_gps_seconds,
    output logic        o_done,
    output logic        o_valid_res,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic        o_summer_time,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [29:0] r_offset;
    logic        sp_v, sp_zero;
    logic [15:0] sp_days;
    logic [16:0] sp_sod;
    logic [15:0] days_next;
    t_date       civ_a, civ_b;

    logic        r_cv    [CIV_LAT];
    logic        r_cz    [CIV_LAT];
    logic [16:0] r_csod  [CIV_LAT];
    logic [34:0] r_dw_prod;
    logic [16:0] r_dw_d7;
    logic [2:0]  r_dow   [CIV_LAT-1];
    logic [16:0] n_d7;
    logic [16:0] n_dowfull;

    logic [5:0]  n_t;
    logic [11:0] n_tprod;
    logic [5:0]  n_tm;
    logic [4:0]  n_ls;
    logic        n_dst;
    logic        r_d_v, r_d_z, r_d_dst;
    logic [16:0] r_d_sod;
    t_date       r_d_a, r_d_b;

    logic [17:0] n_lsod;
    logic        n_wrap;
    logic [17:0] n_sodl;
    logic        r_e_v, r_e_z, r_e_dst;
    logic [16:0] r_e_sod;
    t_date       r_e_date;

    logic        r_hv    [HM_LAT];
    logic        r_hz    [HM_LAT];
    logic        r_hdst  [HM_LAT];
    t_date       r_hdate [HM_LAT];
    logic [4:0]  hm_hour;
    logic [5:0]  hm_minute;

    logic        r_done, r_valid_res, r_summer;
    t_date       r_date;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign prdata = {2'b0, r_offset};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= EPOCH_OFFSET_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_EPOCH_OFFSET)) begin
            r_offset <= pwdata[29:0];
        end
    end

    gsc_split u_split (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (start),
        .i_gps_seconds (i_gps_seconds),
        .i_offset      (r_offset),
        .o_valid       (sp_v),
        .o_zero        (sp_zero),
        .o_days        (sp_days),
        .o_sod         (sp_sod)
    );

    // convert both the UTC day and the following day; local time picks one
    assign days_next = sp_days + 16'd1;

    gsc_civil u_civ_a (.i_clk(i_clk), .i_days(sp_days),   .o_date(civ_a));
    gsc_civil u_civ_b (.i_clk(i_clk), .i_days(days_next), .o_date(civ_b));

    // weekday of the UTC day, 0 is Sunday
    assign n_d7      = {1'b0, sp_days} + 17'd4;
    assign n_dowfull = r_dw_d7 - ({2'b0, r_dw_prod[34:20]} * 17'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CIV_LAT; i++) r_cv[i] <= 1'b0;
        end else begin
            r_cv[0] <= sp_v;
            for (int i = 1; i < CIV_LAT; i++) r_cv[i] <= r_cv[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cz[0]   <= sp_zero;
        r_csod[0] <= sp_sod;
        for (int i = 1; i < CIV_LAT; i++) begin
            r_cz[i]   <= r_cz[i-1];
            r_csod[i] <= r_csod[i-1];
        end
        r_dw_prod <= {18'b0, n_d7} * {17'b0, DOW_RECIP};
        r_dw_d7   <= n_d7;
        r_dow[0]  <= n_dowfull[2:0];
        for (int i = 1; i < CIV_LAT - 1; i++) r_dow[i] <= r_dow[i-1];
    end

    // last Sunday of a 31-day month: 31 minus the weekday of the 31st
    assign n_t     = {3'b0, r_dow[CIV_LAT-2]} + 6'd31 - {1'b0, civ_a.day};
    assign n_tprod = {6'b0, n_t} * 12'd37;
    assign n_tm    = n_t - ({3'b0, n_tprod[10:8]} * 6'd7);
    assign n_ls    = 5'd31 - {2'b0, n_tm[2:0]};

    always_comb begin
        n_dst = 1'b0;
        if ((civ_a.month > 4'd3) && (civ_a.month < 4'd10)) begin
            n_dst = 1'b1;
        end else if (civ_a.month == 4'd3) begin
            n_dst = (civ_a.day > n_ls) ||
                    ((civ_a.day == n_ls) && (r_csod[CIV_LAT-1] >= {5'b0, SECS_PER_HOUR}));
        end else if (civ_a.month == 4'd10) begin
            n_dst = (civ_a.day < n_ls) ||
                    ((civ_a.day == n_ls) && (r_csod[CIV_LAT-1] < {5'b0, SECS_PER_HOUR}));
        end
    end

    // add the zone offset and roll into the next day when needed
    assign n_lsod = {1'b0, r_d_sod} + (r_d_dst ? 18'd7200 : 18'd3600);
    assign n_wrap = (n_lsod >= {1'b0, SECS_PER_DAY});
    assign n_sodl = n_wrap ? (n_lsod - {1'b0, SECS_PER_DAY}) : n_lsod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else begin
            r_d_v <= r_cv[CIV_LAT-1];
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_z    <= r_cz[CIV_LAT-1];
        r_d_dst  <= n_dst;
        r_d_sod  <= r_csod[CIV_LAT-1];
        r_d_a    <= civ_a;
        r_d_b    <= civ_b;
        r_e_z    <= r_d_z;
        r_e_dst  <= r_d_dst;
        r_e_sod  <= n_sodl[16:0];
        r_e_date <= n_wrap ? r_d_b : r_d_a;
    end

    gsc_hm u_hm (
        .i_clk    (i_clk),
        .i_sod    (r_e_sod),
        .o_hour   (hm_hour),
        .o_minute (hm_minute)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HM_LAT; i++) r_hv[i] <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_hv[0] <= r_e_v;
            for (int i = 1; i < HM_LAT; i++) r_hv[i] <= r_hv[i-1];
            r_done <= r_hv[HM_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_hz[0]    <= r_e_z;
        r_hdst[0]  <= r_e_dst;
        r_hdate[0] <= r_e_date;
        for (int i = 1; i < HM_LAT; i++) begin
            r_hz[i]    <= r_hz[i-1];
            r_hdst[i]  <= r_hdst[i-1];
            r_hdate[i] <= r_hdate[i-1];
        end
        // zero input: drop every field to zero
        r_valid_res <= !r_hz[HM_LAT-1];
        r_summer    <= r_hz[HM_LAT-1] ? 1'b0 : r_hdst[HM_LAT-1];
        r_date      <= r_hz[HM_LAT-1] ? '0 : r_hdate[HM_LAT-1];
        r_hour      <= r_hz[HM_LAT-1] ? 5'd0 : hm_hour;
        r_minute    <= r_hz[HM_LAT-1] ? 6'd0 : hm_minute;
    end

    assign o_done        = r_done;
    assign o_valid_res   = r_valid_res;
    assign o_year        = r_date.year;
    assign o_month       = r_date.month;
    assign o_day         = r_date.day;
    assign o_hour        = r_hour;
    assign o_minute      = r_minute;
    assign o_summer_time = r_summer;

endmodule

`default_nettype wire

// File: sv/gsc_split.sv
// Front pipeline: adds the epoch offset and splits UTC seconds into days
// and seconds of the day. Three register stages. Uses gsc_pkg.
`default_nettype none

module gsc_split import gsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_gps_seconds,
    input  logic [29:0] i_offset,
    output logic        o_valid,
    output logic        o_zero,
    output logic [15:0] o_days,
    output logic [16:0] o_sod
);

    logic        r_v1, r_v2, r_v3;
    logic        r_z1, r_z2, r_z3;
    logic [32:0] r_utc1, r_utc2;
    logic [52:0] r_pq;
    logic [15:0] r_days;
    logic [16:0] r_sod;
    logic [32:0] n_utc;
    logic [15:0] n_days;
    logic [32:0] n_rem;

    assign n_utc  = {1'b0, i_gps_seconds} + {3'b0, i_offset};
    assign n_days = r_pq[51:36];
    assign n_rem  = r_utc2 - ({17'b0, n_days} * {16'b0, SECS_PER_DAY});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_utc1 <= n_utc;
        r_z1   <= (i_gps_seconds == 32'd0);
        // divide by 86400 as (utc >> 7) / 675
        r_pq   <= {27'b0, r_utc1[32:7]} * {26'b0, DAY_RECIP};
        r_utc2 <= r_utc1;
        r_z2   <= r_z1;
        r_days <= n_days;
        r_sod  <= n_rem[16:0];
        r_z3   <= r_z2;
    end

    assign o_valid = r_v3;
    assign o_zero  = r_z3;
    assign o_days  = r_days;
    assign o_sod   = r_sod;

endmodule

`default_nettype wire

// File: sv/gsc_civil.sv
// Civil date from a day count since 1970-01-01, six register stages.
// Era/day-of-era method with reciprocal multiplies. Uses gsc_pkg.
`default_nettype none

module gsc_civil import gsc_pkg::*; (
    input  logic        i_clk,
    input  logic [15:0] i_days,
    output t_date       o_date
);

    logic [19:0] n_z;
    logic        n_era5;
    logic [19:0] n_doe;
    logic [17:0] r_c1_doe, r_c2_doe, r_c3_doe;
    logic        r_c1_era5, r_c2_era5, r_c3_era5, r_c4_era5, r_c5_era5;
    logic [31:0] r_c2_p1;
    logic [2:0]  r_c2_cent;
    logic        r_c2_last;
    logic [17:0] n_num;
    logic [35:0] r_c3_p2;
    logic [8:0]  n_yoe;
    logic [1:0]  n_ycent;
    logic [17:0] n_ydays;
    logic [17:0] n_doy;
    logic [8:0]  r_c4_yoe, r_c5_yoe;
    logic [8:0]  r_c4_doy, r_c5_doy;
    logic [10:0] n_mnum;
    logic [23:0] r_c5_p3;
    logic [3:0]  n_mp;
    logic [3:0]  n_month;
    logic [9:0]  n_day;
    logic [11:0] n_year;
    t_date       r_date;

    // stage 1: shift to the 0000-03-01 epoch, split off the era (4 or 5 here)
    assign n_z    = {4'b0, i_days} + 20'd719468;
    assign n_era5 = (n_z >= 20'd730485);
    assign n_doe  = n_z - (n_era5 ? 20'd730485 : 20'd584388);

    // stage 3: leap-day corrected day of era
    assign n_num = r_c2_doe - {10'b0, r_c2_p1[31:24]} + {15'b0, r_c2_cent}
                 - {17'b0, r_c2_last};

    // stage 4: year of era and day of the March-based year
    assign n_yoe   = r_c3_p2[34:26];
    assign n_ycent = (n_yoe >= 9'd300) ? 2'd3 :
                     (n_yoe >= 9'd200) ? 2'd2 :
                     (n_yoe >= 9'd100) ? 2'd1 : 2'd0;
    assign n_ydays = ({9'b0, n_yoe} * 18'd365) + {11'b0, n_yoe[8:2]} - {16'b0, n_ycent};
    assign n_doy   = r_c3_doe - n_ydays;

    assign n_mnum = ({r_c4_doy, 2'b0} + {2'b0, r_c4_doy}) + 11'd2;

    // stage 6: month, day and year
    assign n_mp    = r_c5_p3[23:20];
    assign n_day   = {1'b0, r_c5_doy} - {1'b0, month_start(n_mp)} + 10'd1;
    assign n_month = (n_mp < 4'd10) ? (n_mp + 4'd3) : (n_mp - 4'd9);
    assign n_year  = {3'b0, r_c5_yoe} + (r_c5_era5 ? 12'd2000 : 12'd1600)
                   + {11'b0, (n_month <= 4'd2)};

    always_ff @(posedge i_clk) begin
        r_c1_doe  <= n_doe[17:0];
        r_c1_era5 <= n_era5;

        r_c2_p1   <= {16'b0, r_c1_doe[17:2]} * {16'b0, DIV365_RECIP};
        r_c2_cent <= (r_c1_doe >= 18'd146096) ? 3'd4 :
                     (r_c1_doe >= 18'd109572) ? 3'd3 :
                     (r_c1_doe >= 18'd73048)  ? 3'd2 :
                     (r_c1_doe >= 18'd36524)  ? 3'd1 : 3'd0;
        r_c2_last <= (r_c1_doe == 18'd146096);
        r_c2_doe  <= r_c1_doe;
        r_c2_era5 <= r_c1_era5;

        r_c3_p2   <= {18'b0, n_num} * {18'b0, YOE_RECIP};
        r_c3_doe  <= r_c2_doe;
        r_c3_era5 <= r_c2_era5;

        r_c4_yoe  <= n_yoe;
        r_c4_doy  <= n_doy[8:0];
        r_c4_era5 <= r_c3_era5;

        r_c5_p3   <= {13'b0, n_mnum} * {11'b0, MP_RECIP};
        r_c5_yoe  <= r_c4_yoe;
        r_c5_doy  <= r_c4_doy;
        r_c5_era5 <= r_c4_era5;

        r_date.year  <= n_year;
        r_date.month <= n_month;
        r_date.day   <= n_day[4:0];
    end

    assign o_date = r_date;

endmodule

`default_nettype wire

// File: sv/gsc_hm.sv
// Hour and minute from local seconds of the day, three register stages.
// Reciprocal multiplies for /3600 and /60. Uses gsc_pkg.
`default_nettype none

module gsc_hm import gsc_pkg::*; (
    input  logic        i_clk,
    input  logic [16:0] i_sod,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute
);

    logic [26:0] r_ph;
    logic [16:0] r_sod;
    logic [4:0]  n_hour;
    logic [16:0] n_rem;
    logic [4:0]  r_hour2, r_hour3;
    logic [11:0] r_rem;
    logic [20:0] r_pm;

    assign n_hour = r_ph[25:21];
    assign n_rem  = r_sod - ({12'b0, n_hour} * {5'b0, SECS_PER_HOUR});

    always_ff @(posedge i_clk) begin
        r_ph    <= {14'b0, i_sod[16:4]} * {13'b0, HOUR_RECIP};
        r_sod   <= i_sod;
        r_hour2 <= n_hour;
        r_rem   <= n_rem[11:0];
        r_pm    <= {11'b0, r_rem[11:2]} * {10'b0, MIN_RECIP};
        r_hour3 <= r_hour2;
    end

    assign o_hour   = r_hour3;
    assign o_minute = r_pm[19:14];

endmodule

`default_nettype wire
